// ----- rtl/hsv2rgb_pkg.sv -----
`default_nettype none

package hsv2rgb_pkg;

   // strip length, indices at or above this are flagged out of range
   localparam int unsigned PIXEL_COUNT = 144;
   localparam int unsigned INDEX_W     = 10;

   // hue in 1/64 degree: one sextant is 60 degrees, full circle 360 degrees
   localparam int unsigned HUE_W       = 15;
   localparam int unsigned HUE_SEXTANT = 3840;
   localparam int unsigned HUE_FULL    = 23040;
   localparam int unsigned HUE_REM_W   = 12;

   // 1.8 fractions and their 16-fraction-bit products
   localparam int unsigned FRAC_W      = 9;
   localparam int unsigned PROD_W      = 2 * FRAC_W;
   // signed sum of a channel term and m
   localparam int unsigned SUM_W       = PROD_W + 2;
   localparam int unsigned LEVEL_W     = 8;
   localparam int unsigned BRIGHT_W    = 5;

   // ramp slope F = floor(e * 65536 / 3840) = 17e + floor(e / 15)
   // floor(e / 15) = (e * DIV15_MUL) >> DIV15_SHIFT, exact for e below 4681
   localparam int unsigned DIV15_MUL   = 4370;
   localparam int unsigned DIV15_SHIFT = 16;
   localparam int unsigned SLOPE_W     = 17;

   // channel scale: floor(sum * 255 / 65536)
   localparam int unsigned LEVEL_MAX   = 255;

   // hue sextants in order around the circle
   typedef enum logic [2:0] {
      SEXT_RED_YELLOW,
      SEXT_YELLOW_GREEN,
      SEXT_GREEN_CYAN,
      SEXT_CYAN_BLUE,
      SEXT_BLUE_MAGENTA,
      SEXT_MAGENTA_RED
   } sextant_type;

endpackage

`default_nettype wire

// ----- rtl/hsv2rgb_level.sv -----
`default_nettype none

module hsv2rgb_level
   import hsv2rgb_pkg::*;
(
   input  wire logic signed [SUM_W-1:0]   sum,
   output logic             [LEVEL_W-1:0] level
);

   localparam int unsigned SCALED_W = SUM_W + 8;

   logic signed [SCALED_W-1:0] scaled;
   logic        [SCALED_W-DIV15_SHIFT-1:0] whole;

   // sum * 255 as a shift and subtract
   assign scaled = {sum, 8'b0} - SCALED_W'(sum);
   assign whole  = scaled[SCALED_W-1:DIV15_SHIFT];

   // negative or zero gives black, above full scale clamps
   always_comb begin
      if (sum <= 0) begin
         level = '0;
      end else if (whole > (SCALED_W-DIV15_SHIFT)'(LEVEL_MAX)) begin
         level = LEVEL_W'(LEVEL_MAX);
      end else begin
         level = whole[LEVEL_W-1:0];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/hsv_to_rgb_pixel.sv -----
`default_nettype none

// channel  | direction | handshake              | payload
// req      | in        | req_tvalid/req_tready  | tdata: index, hue, sat, value, brightness
// rsp      | out       | rsp_tvalid/rsp_tready  | tdata: index, r, g, b, brightness
//          |           |                        | tuser: in_range
//
// four register stages: chroma and hue ramp position, ramp slope and m,
// x = chroma * slope, channel levels into the output register
// one pixel per clock while rsp_tready stays high; a req transfer is registered through stages 1 to 4 before rsp valid
// reset clears only the stage valid bits
// each stage holds while the next one is full and stalled, bubbles close up

module hsv_to_rgb_pixel
   import hsv2rgb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   // pixel_index[9:0], hue[24:10], saturation[33:25], value_level[42:34],
   // brightness[47:43]
   input  wire logic [47:0] req_tdata,

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // out_index[9:0], red[17:10], green[25:18], blue[33:26],
   // out_brightness[38:34], zero[39]
   output logic [39:0]      rsp_tdata,
   // in_range[0]
   output logic [0:0]       rsp_tuser
);

   // input fields
   logic [INDEX_W-1:0]  req_index;
   logic [HUE_W-1:0]    req_hue;
   logic [FRAC_W-1:0]   req_sat;
   logic [FRAC_W-1:0]   req_val;
   logic [BRIGHT_W-1:0] req_bright;

   assign req_index  = req_tdata[9:0];
   assign req_hue    = req_tdata[24:10];
   assign req_sat    = req_tdata[33:25];
   assign req_val    = req_tdata[42:34];
   assign req_bright = req_tdata[47:43];

   // stage valid bits and advance enables
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic s1_go, s2_go, s3_go, s4_go;

   assign s4_go      = !s4_vld_ff || rsp_tready;
   assign s3_go      = !s3_vld_ff || s4_go;
   assign s2_go      = !s2_vld_ff || s3_go;
   assign s1_go      = !s1_vld_ff || s2_go;
   assign req_tready = s1_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         if (s1_go) s1_vld_ff <= req_tvalid;
         if (s2_go) s2_vld_ff <= s1_vld_ff;
         if (s3_go) s3_vld_ff <= s2_vld_ff;
         if (s4_go) s4_vld_ff <= s3_vld_ff;
      end
   end

   // pass-through fields: index, brightness and in_range travel down all stages, black and sextant down to stage 3
   logic [INDEX_W-1:0]  s1_index_ff, s2_index_ff, s3_index_ff, s4_index_ff;
   logic [BRIGHT_W-1:0] s1_bright_ff, s2_bright_ff, s3_bright_ff, s4_bright_ff;
   logic                s1_ok_ff, s2_ok_ff, s3_ok_ff, s4_ok_ff;
   logic                s1_black_ff, s2_black_ff, s3_black_ff;
   sextant_type         s1_sext_ff, s2_sext_ff, s3_sext_ff;

   // stage 1: chroma, sextant and position on the ramp
   logic                 s1_ok_in, s1_black_in;
   sextant_type          s1_sext_in;
   logic [HUE_W-1:0]     s1_base;
   logic [HUE_W-1:0]     s1_rem_full;
   logic [HUE_REM_W-1:0] s1_rem;
   logic [HUE_REM_W-1:0] s1_ramp_in, s1_ramp_ff;
   logic [PROD_W-1:0]    s1_chroma_in, s1_chroma_ff;
   logic [FRAC_W-1:0]    s1_val_ff;

   always_comb begin
      s1_ok_in    = {1'b0, req_index} < (INDEX_W+1)'(PIXEL_COUNT);
      s1_black_in = !s1_ok_in || (req_hue >= HUE_W'(HUE_FULL));

      if (req_hue < HUE_W'(HUE_SEXTANT)) begin
         s1_sext_in = SEXT_RED_YELLOW;
      end else if (req_hue < HUE_W'(2 * HUE_SEXTANT)) begin
         s1_sext_in = SEXT_YELLOW_GREEN;
      end else if (req_hue < HUE_W'(3 * HUE_SEXTANT)) begin
         s1_sext_in = SEXT_GREEN_CYAN;
      end else if (req_hue < HUE_W'(4 * HUE_SEXTANT)) begin
         s1_sext_in = SEXT_CYAN_BLUE;
      end else if (req_hue < HUE_W'(5 * HUE_SEXTANT)) begin
         s1_sext_in = SEXT_BLUE_MAGENTA;
      end else begin
         s1_sext_in = SEXT_MAGENTA_RED;
      end

      s1_base     = HUE_W'(32'(s1_sext_in) * HUE_SEXTANT);
      s1_rem_full = req_hue - s1_base;
      s1_rem      = s1_rem_full[HUE_REM_W-1:0];

      // rising ramp in even sextants, falling in odd ones
      if (s1_sext_in[0]) begin
         s1_ramp_in = HUE_REM_W'(HUE_SEXTANT) - s1_rem;
      end else begin
         s1_ramp_in = s1_rem;
      end

      s1_chroma_in = PROD_W'(req_val) * PROD_W'(req_sat);
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         s1_index_ff  <= req_index;
         s1_bright_ff <= req_bright;
         s1_ok_ff     <= s1_ok_in;
         s1_black_ff  <= s1_black_in;
         s1_sext_ff   <= s1_sext_in;
         s1_ramp_ff   <= s1_ramp_in;
         s1_chroma_ff <= s1_chroma_in;
         s1_val_ff    <= req_val;
      end
   end

   // stage 2: ramp slope F and offset m = v - c
   localparam int unsigned Q_PROD_W = HUE_REM_W + 13;

   logic [Q_PROD_W-1:0]     s2_q_prod;
   logic [SLOPE_W-1:0]      s2_slope_in, s2_slope_ff;
   logic signed [SUM_W-1:0] s2_offset_in, s2_offset_ff;
   logic [PROD_W-1:0]       s2_chroma_ff;

   always_comb begin
      s2_q_prod    = Q_PROD_W'(s1_ramp_ff) * Q_PROD_W'(DIV15_MUL);
      s2_slope_in  = SLOPE_W'({s1_ramp_ff, 4'b0}) + SLOPE_W'(s1_ramp_ff)
                   + SLOPE_W'(s2_q_prod[Q_PROD_W-1:DIV15_SHIFT]);
      s2_offset_in = $signed(SUM_W'({s1_val_ff, 8'b0})) - $signed(SUM_W'(s1_chroma_ff));
   end

   always_ff @(posedge clock) begin
      if (s2_go) begin
         s2_index_ff  <= s1_index_ff;
         s2_bright_ff <= s1_bright_ff;
         s2_ok_ff     <= s1_ok_ff;
         s2_black_ff  <= s1_black_ff;
         s2_sext_ff   <= s1_sext_ff;
         s2_slope_ff  <= s2_slope_in;
         s2_offset_ff <= s2_offset_in;
         s2_chroma_ff <= s1_chroma_ff;
      end
   end

   // stage 3: x = c * F with 16 fraction bits dropped
   localparam int unsigned X_PROD_W = PROD_W + SLOPE_W;

   logic [X_PROD_W-1:0]     s3_x_prod;
   logic [PROD_W-1:0]       s3_x_in, s3_x_ff;
   logic [PROD_W-1:0]       s3_chroma_ff;
   logic signed [SUM_W-1:0] s3_offset_ff;

   assign s3_x_prod = X_PROD_W'(s2_chroma_ff) * X_PROD_W'(s2_slope_ff);
   assign s3_x_in   = s3_x_prod[PROD_W+DIV15_SHIFT-1:DIV15_SHIFT];

   always_ff @(posedge clock) begin
      if (s3_go) begin
         s3_index_ff  <= s2_index_ff;
         s3_bright_ff <= s2_bright_ff;
         s3_ok_ff     <= s2_ok_ff;
         s3_black_ff  <= s2_black_ff;
         s3_sext_ff   <= s2_sext_ff;
         s3_x_ff      <= s3_x_in;
         s3_chroma_ff <= s2_chroma_ff;
         s3_offset_ff <= s2_offset_ff;
      end
   end

   // stage 4: sextant mapping, add m, scale and clamp into the output register
   logic [PROD_W-1:0]       s4_red_p, s4_green_p, s4_blue_p;
   logic signed [SUM_W-1:0] s4_red_sum, s4_green_sum, s4_blue_sum;
   logic [LEVEL_W-1:0]      s4_red_lvl, s4_green_lvl, s4_blue_lvl;
   logic [LEVEL_W-1:0]      s4_red_ff, s4_green_ff, s4_blue_ff;

   always_comb begin
      case (s3_sext_ff)
         SEXT_RED_YELLOW: begin
            s4_red_p = s3_chroma_ff; s4_green_p = s3_x_ff;      s4_blue_p = '0;
         end
         SEXT_YELLOW_GREEN: begin
            s4_red_p = s3_x_ff;      s4_green_p = s3_chroma_ff; s4_blue_p = '0;
         end
         SEXT_GREEN_CYAN: begin
            s4_red_p = '0;           s4_green_p = s3_chroma_ff; s4_blue_p = s3_x_ff;
         end
         SEXT_CYAN_BLUE: begin
            s4_red_p = '0;           s4_green_p = s3_x_ff;      s4_blue_p = s3_chroma_ff;
         end
         SEXT_BLUE_MAGENTA: begin
            s4_red_p = s3_x_ff;      s4_green_p = '0;           s4_blue_p = s3_chroma_ff;
         end
         default: begin
            s4_red_p = s3_chroma_ff; s4_green_p = '0;           s4_blue_p = s3_x_ff;
         end
      endcase

      s4_red_sum   = $signed(SUM_W'(s4_red_p))   + s3_offset_ff;
      s4_green_sum = $signed(SUM_W'(s4_green_p)) + s3_offset_ff;
      s4_blue_sum  = $signed(SUM_W'(s4_blue_p))  + s3_offset_ff;
   end

   hsv2rgb_level u_red_level   (.sum(s4_red_sum),   .level(s4_red_lvl));
   hsv2rgb_level u_green_level (.sum(s4_green_sum), .level(s4_green_lvl));
   hsv2rgb_level u_blue_level  (.sum(s4_blue_sum),  .level(s4_blue_lvl));

   always_ff @(posedge clock) begin
      if (s4_go) begin
         s4_index_ff  <= s3_index_ff;
         s4_bright_ff <= s3_bright_ff;
         s4_ok_ff     <= s3_ok_ff;
         s4_red_ff    <= s3_black_ff ? '0 : s4_red_lvl;
         s4_green_ff  <= s3_black_ff ? '0 : s4_green_lvl;
         s4_blue_ff   <= s3_black_ff ? '0 : s4_blue_lvl;
      end
   end

   // result transfer
   assign rsp_tvalid = s4_vld_ff;
   assign rsp_tdata  = {1'b0, s4_bright_ff, s4_blue_ff, s4_green_ff, s4_red_ff, s4_index_ff};
   assign rsp_tuser  = s4_ok_ff;

endmodule

`default_nettype wire

// ----- verif/tb_hsv_to_rgb_pixel.sv -----
`default_nettype none

module tb_hsv_to_rgb_pixel;
   import hsv2rgb_pkg::*;

   typedef struct {
      logic [INDEX_W-1:0]  index;
      logic [LEVEL_W-1:0]  red;
      logic [LEVEL_W-1:0]  green;
      logic [LEVEL_W-1:0]  blue;
      logic [BRIGHT_W-1:0] bright;
      logic                in_range;
   } pixel_rgb_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // pixel_index[9:0], hue[24:10], saturation[33:25], value_level[42:34],
   // brightness[47:43]
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // out_index[9:0], red[17:10], green[25:18], blue[33:26],
   // out_brightness[38:34], zero[39]
   logic [39:0] rsp_tdata;
   // in_range[0]
   logic [0:0]  rsp_tuser;

   pixel_rgb_type expected_pixels[$];
   int unsigned error_count = 0;
   int unsigned pixels_sent = 0;
   int unsigned pixels_checked = 0;
   int unsigned off_strip_sent = 0;
   int unsigned black_hue_sent = 0;
   int unsigned req_stall_cycles = 0;
   bit          src_idle_on = 1'b1;
   bit          sink_idle_on = 1'b1;
   int unsigned sink_stall = 0;
   int unsigned sink_hold = 0;

   hsv_to_rgb_pixel dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   // channel level from a signed sum with 16 fraction bits
   function automatic logic [LEVEL_W-1:0] channel_level(input longint sum);
      longint lvl;
      if (sum <= 0) begin
         return '0;
      end
      lvl = (sum * 255) / 65536;
      if (lvl > 255) begin
         lvl = 255;
      end
      return lvl[LEVEL_W-1:0];
   endfunction

   // expected rgb levels for one hsv pixel
   function automatic pixel_rgb_type hsv_pixel_to_rgb(input logic [INDEX_W-1:0] idx,
                                                     input logic [HUE_W-1:0] hue,
                                                     input logic [FRAC_W-1:0] sat,
                                                     input logic [FRAC_W-1:0] val,
                                                     input logic [BRIGHT_W-1:0] bri);
      pixel_rgb_type res;
      longint      sextant_len;
      longint      chroma;
      longint      ramp_dist;
      longint      slope;
      longint      x_term;
      longint      m_term;
      longint      red_p;
      longint      green_p;
      longint      blue_p;
      sextant_type sextant;
      sextant_len  = longint'(HUE_SEXTANT);
      res.index    = idx;
      res.bright   = bri;
      res.in_range = (int'(idx) < int'(PIXEL_COUNT));
      res.red      = '0;
      res.green    = '0;
      res.blue     = '0;
      if (res.in_range && int'(hue) < int'(HUE_FULL)) begin
         chroma    = longint'(val) * longint'(sat);
         ramp_dist = (longint'(hue) % (2 * sextant_len)) - sextant_len;
         if (ramp_dist < 0) begin
            ramp_dist = -ramp_dist;
         end
         slope   = ((sextant_len - ramp_dist) * 65536) / sextant_len;
         x_term  = (chroma * slope) / 65536;
         m_term  = longint'(val) * 256 - chroma;
         sextant = sextant_type'(3'(longint'(hue) / sextant_len));
         case (sextant)
            SEXT_RED_YELLOW: begin
               red_p = chroma; green_p = x_term; blue_p = 0;
            end
            SEXT_YELLOW_GREEN: begin
               red_p = x_term; green_p = chroma; blue_p = 0;
            end
            SEXT_GREEN_CYAN: begin
               red_p = 0; green_p = chroma; blue_p = x_term;
            end
            SEXT_CYAN_BLUE: begin
               red_p = 0; green_p = x_term; blue_p = chroma;
            end
            SEXT_BLUE_MAGENTA: begin
               red_p = x_term; green_p = 0; blue_p = chroma;
            end
            default: begin
               red_p = chroma; green_p = 0; blue_p = x_term;
            end
         endcase
         res.red   = channel_level(red_p + m_term);
         res.green = channel_level(green_p + m_term);
         res.blue  = channel_level(blue_p + m_term);
      end
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [15:0] got,
                                  input logic [15:0] want);
      error_count++;
      if (error_count <= 30) begin
         $display("mismatch on %s: got %0d expected %0d (result %0d)",
                  field, got, want, pixels_checked);
      end
   endtask

   // one pixel transfer on the req side, with a random gap first when source idling is on
   task automatic send_pixel(input logic [INDEX_W-1:0] idx, input logic [HUE_W-1:0] hue,
                             input logic [FRAC_W-1:0] sat, input logic [FRAC_W-1:0] val,
                             input logic [BRIGHT_W-1:0] bri);
      int unsigned gap;
      gap = src_idle_on ? $urandom_range(0, 11) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {bri, val, sat, hue, idx};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      expected_pixels.push_back(hsv_pixel_to_rgb(idx, hue, sat, val, bri));
      pixels_sent++;
      if (int'(idx) >= int'(PIXEL_COUNT)) begin
         off_strip_sent++;
      end
      if (int'(hue) >= int'(HUE_FULL)) begin
         black_hue_sent++;
      end
   endtask

   // drop valid and wait for every outstanding result
   task automatic drain_pixels();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   // sink side: long hold-off first, then the per-result stall
   always @(negedge clock) begin
      if (sink_hold > 0) begin
         rsp_tready <= 1'b0;
         sink_hold  <= sink_hold - 1;
      end else if (sink_stall > 0) begin
         rsp_tready <= 1'b0;
         sink_stall <= sink_stall - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare each rsp transfer with the oldest expected pixel, and count req stall cycles
   always @(posedge clock) begin : rsp_check
      pixel_rgb_type want;
      if (!reset && req_tvalid && req_tready !== 1'b1) begin
         req_stall_cycles++;
      end
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         sink_stall <= sink_idle_on ? $urandom_range(0, 11) : 0;
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected result", 16'(rsp_tdata[9:0]), '0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_tdata[9:0] !== want.index)
               report_mismatch("out_index", 16'(rsp_tdata[9:0]), 16'(want.index));
            if (rsp_tdata[17:10] !== want.red)
               report_mismatch("red", 16'(rsp_tdata[17:10]), 16'(want.red));
            if (rsp_tdata[25:18] !== want.green)
               report_mismatch("green", 16'(rsp_tdata[25:18]), 16'(want.green));
            if (rsp_tdata[33:26] !== want.blue)
               report_mismatch("blue", 16'(rsp_tdata[33:26]), 16'(want.blue));
            if (rsp_tdata[38:34] !== want.bright)
               report_mismatch("out_brightness", 16'(rsp_tdata[38:34]), 16'(want.bright));
            if (rsp_tdata[39] !== 1'b0)
               report_mismatch("pad bit", 16'(rsp_tdata[39]), '0);
            if (rsp_tuser[0] !== want.in_range)
               report_mismatch("in_range", 16'(rsp_tuser[0]), 16'(want.in_range));
         end
         pixels_checked++;
      end
   end

   // field extremes, the start of every sextant and some sextant ends, black hue, off-strip index
   task automatic test_directed();
      src_idle_on  = 1'b0;
      sink_idle_on = 1'b0;
      send_pixel(10'd0,   15'd0,     9'd256, 9'd256, 5'd31);
      send_pixel(10'd1,   15'd1920,  9'd256, 9'd256, 5'd0);
      send_pixel(10'd2,   15'd3839,  9'd256, 9'd256, 5'd16);
      send_pixel(10'd3,   15'd3840,  9'd200, 9'd256, 5'd1);
      send_pixel(10'd4,   15'd7679,  9'd256, 9'd200, 5'd2);
      send_pixel(10'd5,   15'd7680,  9'd128, 9'd256, 5'd3);
      send_pixel(10'd6,   15'd11520, 9'd256, 9'd128, 5'd4);
      send_pixel(10'd7,   15'd15360, 9'd64,  9'd192, 5'd5);
      send_pixel(10'd8,   15'd19200, 9'd192, 9'd64,  5'd6);
      send_pixel(10'd9,   15'd23039, 9'd256, 9'd256, 5'd7);
      send_pixel(10'd10,  15'd23040, 9'd256, 9'd256, 5'd8);
      send_pixel(10'd11,  15'h7FFF,  9'd256, 9'd256, 5'd9);
      send_pixel(10'd12,  15'd5000,  9'd0,   9'd256, 5'd10);
      send_pixel(10'd13,  15'd5000,  9'd256, 9'd0,   5'd11);
      send_pixel(10'd14,  15'd9000,  9'h1FF, 9'h1FF, 5'd12);
      send_pixel(10'd15,  15'd13000, 9'h1FF, 9'd100, 5'd13);
      send_pixel(10'd16,  15'd17000, 9'd0,   9'h1FF, 5'd14);
      send_pixel(10'd143, 15'd21000, 9'd300, 9'd256, 5'd31);
      send_pixel(10'd144, 15'd1000,  9'd256, 9'd256, 5'd31);
      send_pixel(10'h3FF, 15'd12000, 9'h1FF, 9'h1FF, 5'd31);
      send_pixel(10'd512, 15'h7FFF,  9'd0,   9'd0,   5'd0);
      drain_pixels();
   endtask

   // random pixels in stretches, idling on either side switched per stretch
   task automatic test_random(input int unsigned count);
      logic [INDEX_W-1:0]  idx;
      logic [HUE_W-1:0]    hue;
      logic [FRAC_W-1:0]   sat;
      logic [FRAC_W-1:0]   val;
      logic [BRIGHT_W-1:0] bri;
      int unsigned         pick;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) begin
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
         end
         idx  = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1023))
                                            : 10'($urandom_range(0, PIXEL_COUNT - 1));
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            hue = 15'($urandom_range(0, 32767));
         end else if (pick == 1) begin
            // right at a sextant edge
            hue = 15'($urandom_range(0, 6) * HUE_SEXTANT - $urandom_range(0, 1));
         end else begin
            hue = 15'($urandom_range(0, HUE_FULL - 1));
         end
         sat = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 511))
                                           : 9'($urandom_range(0, 256));
         val = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 511))
                                           : 9'($urandom_range(0, 256));
         bri = 5'($urandom_range(0, 31));
         send_pixel(idx, hue, sat, val, bri);
      end
      drain_pixels();
   endtask

   // sink holds off long while pixels keep coming, so the pipe backs up
   task automatic test_backpressure();
      src_idle_on  = 1'b0;
      sink_idle_on = 1'b0;
      @(posedge clock);
      sink_hold = 90;
      for (int n = 0; n < 24; n++) begin
         send_pixel(10'($urandom_range(0, PIXEL_COUNT - 1)),
                    15'($urandom_range(0, HUE_FULL - 1)),
                    9'($urandom_range(0, 256)), 9'($urandom_range(0, 256)),
                    5'($urandom_range(0, 31)));
      end
      drain_pixels();
   endtask

   // short bursts, each followed by a full drain before the next
   task automatic test_burst_drain();
      src_idle_on  = 1'b0;
      sink_idle_on = 1'b1;
      for (int b = 0; b < 4; b++) begin
         for (int n = 0; n < 5; n++) begin
            send_pixel(10'($urandom_range(0, 1023)), 15'($urandom_range(0, 32767)),
                       9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                       5'($urandom_range(0, 31)));
         end
         drain_pixels();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(400);
      test_backpressure();
      test_burst_drain();
      repeat (12) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         report_mismatch("results missing", 16'(expected_pixels.size()), '0);
      end
      $display("covered %0d pixels (%0d off strip, %0d black hue), %0d results checked",
               pixels_sent, off_strip_sent, black_hue_sent, pixels_checked);
      $display("req side stalled for %0d cycles, %0d mismatches",
               req_stall_cycles, error_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(12 * 300000);
      $display("timeout with %0d results outstanding", expected_pixels.size());
      $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_level.sv
rtl/hsv_to_rgb_pixel.sv
verif/tb_hsv_to_rgb_pixel.sv
